// File: design/rwp_pkg.sv
// rwp_pkg: shared types and constants for the RIFF/WAVE PCM16 byte parser.
// No dependencies; imported by every module of the parser.
`default_nettype none

package rwp_pkg;

    // chunk tags, little-endian byte order as they arrive
    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    localparam logic [5:0]  MIN_FILE_BYTES = 6'd44;
    localparam logic [31:0] DEFAULT_RATE   = 32'd16000;
    localparam logic [15:0] DEFAULT_CHAN   = 16'd1;
    localparam logic [15:0] DEFAULT_BITS   = 16'd16;
    localparam logic [15:0] FMT_PCM        = 16'd1;
    localparam logic [4:0]  FMT_BODY_MAX   = 5'd16;

    // parser phases
    localparam logic [2:0] PH_RIFF  = 3'd0;
    localparam logic [2:0] PH_CHDR  = 3'd1;
    localparam logic [2:0] PH_FMT   = 3'd2;
    localparam logic [2:0] PH_SKIP  = 3'd3;
    localparam logic [2:0] PH_DATA  = 3'd4;
    localparam logic [2:0] PH_DONE  = 3'd5;
    localparam logic [2:0] PH_ERROR = 3'd6;

    // status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOTWAVE = 2'd1;
    localparam logic [1:0] ST_NODATA  = 2'd2;
    localparam logic [1:0] ST_BADFMT  = 2'd3;

    // result kinds
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // front-to-back queue
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;

    typedef struct packed {
        logic [7:0] file_byte;
        logic       end_of_file;
    } t_in;

    typedef struct packed {
        logic               kind;
        logic signed [15:0] sample;
        logic [1:0]         status;
        logic [15:0]        channel_count;
        logic [31:0]        rate_hz;
        logic               last;
    } t_out;

    // one queue entry: everything one byte produces (a sample, a status, or both)
    typedef struct packed {
        logic               has_smp;
        logic signed [15:0] smp;
        logic               has_st;
        logic [1:0]         st;
        logic [15:0]        chan;
        logic [31:0]        rate;
    } t_evt;

    function automatic logic [7:0] tag_byte(input logic [31:0] tag, input logic [1:0] idx);
        tag_byte = tag[{idx, 3'b000} +: 8];
    endfunction

endpackage

`default_nettype wire

// File: design/rwp_front.sv
// rwp_front: byte classifier and chunk walker of the parser.
// Depends on rwp_pkg; pushes one rwp_pkg::t_evt per result-bearing beat.
`default_nettype none

module rwp_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  rwp_pkg::t_in  i_in,
    output logic          o_ready,
    input  logic          i_full,
    output logic          o_push,
    output rwp_pkg::t_evt o_evt
);
    import rwp_pkg::*;

    logic [2:0]  r_phase,    n_phase;
    logic [5:0]  r_bcnt,     n_bcnt;
    logic [2:0]  r_hidx,     n_hidx;
    logic [31:0] r_tag,      n_tag;
    logic [31:0] r_len,      n_len;
    logic [32:0] r_rem,      n_rem;
    logic [4:0]  r_off,      n_off;
    logic [15:0] r_fmt,      n_fmt;
    logic [15:0] r_chan,     n_chan;
    logic [31:0] r_rate,     n_rate;
    logic [15:0] r_bits,     n_bits;
    logic [8:0]  r_low,      n_low;
    logic [1:0]  r_err,      n_err;

    logic        accept;
    logic [7:0]  b;
    logic [5:0]  pos;
    logic        chk;
    logic [7:0]  want;
    t_evt        evt;

    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;
    assign b       = i_in.file_byte;
    assign pos     = r_bcnt;

    always_comb begin
        n_phase = r_phase;
        n_bcnt  = r_bcnt;
        n_hidx  = r_hidx;
        n_tag   = r_tag;
        n_len   = r_len;
        n_rem   = r_rem;
        n_off   = r_off;
        n_fmt   = r_fmt;
        n_chan  = r_chan;
        n_rate  = r_rate;
        n_bits  = r_bits;
        n_low   = r_low;
        n_err   = r_err;
        chk     = 1'b0;
        want    = 8'h00;
        evt     = '0;

        if (pos < MIN_FILE_BYTES) begin
            n_bcnt = pos + 6'd1;
        end

        case (r_phase)
            PH_RIFF: begin
                if (pos < 6'd4) begin
                    chk  = 1'b1;
                    want = tag_byte(TAG_RIFF, pos[1:0]);
                end else if (pos >= 6'd8 && pos < 6'd12) begin
                    chk  = 1'b1;
                    want = tag_byte(TAG_WAVE, pos[1:0]);
                end
                if (chk && b != want) begin
                    n_err   = ST_NOTWAVE;
                    n_phase = PH_ERROR;
                end else if (pos >= 6'd11) begin
                    n_phase = PH_CHDR;
                    n_hidx  = 3'd0;
                    n_tag   = '0;
                    n_len   = '0;
                end
            end
            PH_CHDR: begin
                if (!r_hidx[2]) begin
                    n_tag[{r_hidx[1:0], 3'b000} +: 8] = b;
                end else begin
                    n_len[{r_hidx[1:0], 3'b000} +: 8] = b;
                end
                n_hidx = r_hidx + 3'd1;
                if (r_hidx == 3'd7) begin
                    if (n_tag == TAG_DATA) begin
                        if (r_fmt != FMT_PCM || r_bits != DEFAULT_BITS) begin
                            n_err   = ST_BADFMT;
                            n_phase = PH_ERROR;
                        end else begin
                            n_rem   = {1'b0, n_len};
                            n_low   = '0;
                            n_phase = (n_len != '0) ? PH_DATA : PH_DONE;
                        end
                    end else begin
                        // body plus pad byte on odd length
                        n_rem = {1'b0, n_len} + {32'd0, n_len[0]};
                        n_off = '0;
                        if (n_len == '0) begin
                            n_phase = PH_CHDR;
                            n_hidx  = 3'd0;
                            n_tag   = '0;
                            n_len   = '0;
                        end else begin
                            n_phase = (n_tag == TAG_FMT) ? PH_FMT : PH_SKIP;
                        end
                    end
                end
            end
            PH_FMT, PH_SKIP: begin
                if (r_phase == PH_FMT && r_off < FMT_BODY_MAX
                        && {27'd0, r_off} < r_len) begin
                    if (r_off < 5'd2) begin
                        n_fmt[{r_off[0], 3'b000} +: 8] = b;
                    end else if (r_off < 5'd4) begin
                        n_chan[{r_off[0], 3'b000} +: 8] = b;
                    end else if (r_off < 5'd8) begin
                        n_rate[{r_off[1:0], 3'b000} +: 8] = b;
                    end else if (r_off >= 5'd14) begin
                        n_bits[{r_off[0], 3'b000} +: 8] = b;
                    end
                end
                if (r_off < FMT_BODY_MAX) begin
                    n_off = r_off + 5'd1;
                end
                n_rem = r_rem - 33'd1;
                if (r_rem == 33'd1) begin
                    n_phase = PH_CHDR;
                    n_hidx  = 3'd0;
                    n_tag   = '0;
                    n_len   = '0;
                end
            end
            PH_DATA: begin
                if (r_low[8]) begin
                    evt.has_smp = 1'b1;
                    evt.smp     = {b, r_low[7:0]};
                    n_low       = '0;
                end else begin
                    n_low = {1'b1, b};
                end
                n_rem = r_rem - 33'd1;
                if (r_rem == 33'd1) begin
                    n_phase = PH_DONE;
                end
            end
            default: begin
            end
        endcase

        evt.chan = n_chan;
        evt.rate = n_rate;

        if (i_in.end_of_file) begin
            evt.has_st = 1'b1;
            if (n_bcnt < MIN_FILE_BYTES) begin
                evt.st = ST_NOTWAVE;
            end else if (n_err != ST_OK) begin
                evt.st = n_err;
            end else if (n_phase == PH_DATA || n_phase == PH_DONE) begin
                evt.st = ST_OK;
            end else begin
                evt.st = ST_NODATA;
            end
            // back to the power-on state for the next file
            n_phase = PH_RIFF;
            n_bcnt  = '0;
            n_hidx  = '0;
            n_tag   = '0;
            n_len   = '0;
            n_rem   = '0;
            n_off   = '0;
            n_fmt   = '0;
            n_chan  = DEFAULT_CHAN;
            n_rate  = DEFAULT_RATE;
            n_bits  = DEFAULT_BITS;
            n_low   = '0;
            n_err   = ST_OK;
        end
    end

    assign o_push = accept && (evt.has_smp || evt.has_st);
    assign o_evt  = evt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_RIFF;
            r_bcnt  <= '0;
            r_hidx  <= '0;
            r_tag   <= '0;
            r_len   <= '0;
            r_rem   <= '0;
            r_off   <= '0;
            r_fmt   <= '0;
            r_chan  <= DEFAULT_CHAN;
            r_rate  <= DEFAULT_RATE;
            r_bits  <= DEFAULT_BITS;
            r_low   <= '0;
            r_err   <= ST_OK;
        end else if (accept) begin
            r_phase <= n_phase;
            r_bcnt  <= n_bcnt;
            r_hidx  <= n_hidx;
            r_tag   <= n_tag;
            r_len   <= n_len;
            r_rem   <= n_rem;
            r_off   <= n_off;
            r_fmt   <= n_fmt;
            r_chan  <= n_chan;
            r_rate  <= n_rate;
            r_bits  <= n_bits;
            r_low   <= n_low;
            r_err   <= n_err;
        end
    end

endmodule

`default_nettype wire

// File: design/rwp_fifo.sv
// rwp_fifo: short event queue between the parser front and the result back end.
// Depends on rwp_pkg (t_evt, Q_DEPTH, Q_AW).
`default_nettype none

module rwp_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  rwp_pkg::t_evt i_evt,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_nonempty,
    output rwp_pkg::t_evt o_head
);
    import rwp_pkg::*;

    t_evt          r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wptr;
    logic [Q_AW-1:0] r_rptr;
    logic [Q_AW:0]   r_cnt;
    logic            do_pop;

    assign o_full     = (r_cnt == (Q_AW+1)'(Q_DEPTH));
    assign o_nonempty = (r_cnt != '0);
    assign o_head     = r_mem[r_rptr];
    assign do_pop     = i_pop && o_nonempty;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_evt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + Q_AW'(1);
            end
            if (do_pop) begin
                r_rptr <= r_rptr + Q_AW'(1);
            end
            if (i_push && !do_pop) begin
                r_cnt <= r_cnt + (Q_AW+1)'(1);
            end else if (!i_push && do_pop) begin
                r_cnt <= r_cnt - (Q_AW+1)'(1);
            end
        end
    end

endmodule

`default_nettype wire

// File: design/rwp_back.sv
// rwp_back: turns queued events into result beats behind an output register.
// Depends on rwp_pkg; an event with a sample and a status yields two beats.
`default_nettype none

module rwp_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_nonempty,
    input  rwp_pkg::t_evt i_head,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_ready,
    output rwp_pkg::t_out o_out
);
    import rwp_pkg::*;

    logic r_ov;
    logic r_smp_done;
    t_out r_out;
    logic take;
    logic load;
    logic send_smp;
    t_out nxt;

    assign take     = !r_ov || i_ready;
    assign load     = take && i_nonempty;
    assign send_smp = i_head.has_smp && !r_smp_done;
    assign o_pop    = load && !(send_smp && i_head.has_st);
    assign o_valid  = r_ov;
    assign o_out    = r_out;

    always_comb begin
        nxt               = '0;
        nxt.channel_count = i_head.chan;
        nxt.rate_hz       = i_head.rate;
        if (send_smp) begin
            nxt.kind   = KIND_SAMPLE;
            nxt.sample = i_head.smp;
        end else begin
            nxt.kind   = KIND_STATUS;
            nxt.status = i_head.st;
            nxt.last   = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= nxt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov       <= 1'b0;
            r_smp_done <= 1'b0;
        end else if (take) begin
            r_ov <= i_nonempty;
            if (load) begin
                r_smp_done <= send_smp && i_head.has_st;
            end
        end
    end

endmodule

`default_nettype wire

// File: design/riff_wave_pcm16_parser.sv
// riff_wave_pcm16_parser: top level of the WAV (RIFF/WAVE, PCM16) byte parser.
// Path: a result beat is registered in the event queue and then in the output register.
// Throughput: one byte per cycle while the event queue is not full; a final byte that
//   also closes a sample gives two output beats, the sample beat before the status beat.
// Reset: i_rst_n synchronous active low; clears parser state, queue and output valid.
// Depends on rwp_pkg, rwp_front, rwp_fifo, rwp_back.
`default_nettype none

module riff_wave_pcm16_parser (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  rwp_pkg::t_in  i_in,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output rwp_pkg::t_out o_out
);
    import rwp_pkg::*;

    // front -> queue
    logic push;
    t_evt push_evt;
    logic q_full;

    // queue -> back
    logic q_nonempty;
    t_evt q_head;
    logic q_pop;

    // Front: walks the RIFF header and chunk headers one beat at a time, captures
    // fmt fields, pairs data bytes into samples and builds the end-of-file status.
    // It stalls only on a full queue, which fills when the output is held back.
    rwp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_in    (i_in),
        .o_ready (o_in_ready),
        .i_full  (q_full),
        .o_push  (push),
        .o_evt   (push_evt)
    );

    // Queue: absorbs output backpressure and the extra beat of the last byte.
    rwp_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_evt      (push_evt),
        .o_full     (q_full),
        .i_pop      (q_pop),
        .o_nonempty (q_nonempty),
        .o_head     (q_head)
    );

    // Back: registered output; splits sample+status events into two beats.
    rwp_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_nonempty (q_nonempty),
        .i_head     (q_head),
        .o_pop      (q_pop),
        .o_valid    (o_out_valid),
        .i_ready    (i_out_ready),
        .o_out      (o_out)
    );

endmodule

`default_nettype wire

// File: design/rwp_chk.sv
// rwp_chk: port-level checks for riff_wave_pcm16_parser, attached by bind.
// Depends on rwp_pkg and the top level's port list.
`default_nettype none

module rwp_chk (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_ready,
    input rwp_pkg::t_in  i_in,
    input logic          o_out_valid,
    input logic          i_out_ready,
    input rwp_pkg::t_out o_out
);
    import rwp_pkg::*;

    // a stalled input beat holds
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=> i_in_valid && $stable(i_in))
        else $error("input beat changed while stalled");

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("result beat changed while stalled");

    // sample beats carry no status and never close a file
    a_sample_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.kind == KIND_SAMPLE |-> !o_out.last && o_out.status == ST_OK)
        else $error("sample beat with status or last");

    // status beats are the last of the file and carry a zero sample
    a_status_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.kind == KIND_STATUS |-> o_out.last && o_out.sample == 16'sd0)
        else $error("status beat malformed");

    // reset empties the output
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind riff_wave_pcm16_parser rwp_chk u_rwp_chk (.*);

`default_nettype wire

// File: tb/tb_riff_wave_pcm16_parser.sv
// Self-checking testbench for riff_wave_pcm16_parser: WAV byte streams in, samples and status out.
// Depends on rwp_pkg (beat types, tags, phase and status codes) and the parser RTL.
`timescale 1ns / 1ps

module tb_riff_wave_pcm16_parser;
    import rwp_pkg::*;

    logic  i_clk;
    logic  i_rst_n;
    logic  i_in_valid;
    logic  o_in_ready;
    t_in   i_in;
    logic  o_out_valid;
    logic  i_out_ready;
    t_out  o_out;

    riff_wave_pcm16_parser dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    // -------------------------------------------------------------------------
    // Clock, run limit
    // -------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Run limit: roughly ten times the slowest legal run with every gap and stall
    // at its longest and every byte closing a sample plus a status beat.
    initial begin
        #8_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // -------------------------------------------------------------------------
    // Shared knobs and bookkeeping
    // -------------------------------------------------------------------------
    int   fail_count   = 0;
    int   tx_gap_pct   = 0;     // chance (%) of an idle gap before an input beat
    int   rx_stall_pct = 0;     // chance (%) per cycle that the sink starts a stall
    int   rx_hold      = 0;     // forced sink hold-off, counted down by the sink
    int   rx_stall     = 0;
    int   bytes_sent   = 0;     // input beats accepted so far

    t_out       expected_beats[$];  // predicted output beats, oldest first
    logic [7:0] wav_bytes[$];       // file under construction

    // -------------------------------------------------------------------------
    // Parser model: mirrors the byte-serial WAV walk, one call per accepted beat
    // -------------------------------------------------------------------------
    logic [2:0]  ph;
    logic [5:0]  seen_bytes;    // saturates at 44
    logic [2:0]  hdr_pos;
    logic [31:0] cur_tag;
    logic [31:0] cur_len;
    logic [32:0] body_left;     // bytes left in the body, with the pad byte of an odd non-data chunk
    logic [4:0]  fmt_pos;       // saturates at 16
    logic [15:0] fmt_code;
    logic [15:0] chan_cnt;
    logic [31:0] rate_val;
    logic [15:0] bits_val;
    logic        lo_valid;
    logic [7:0]  lo_byte;
    logic [1:0]  err_code;

    function automatic void clear_parser_model();
        ph         = PH_RIFF;
        seen_bytes = '0;
        hdr_pos    = '0;
        cur_tag    = '0;
        cur_len    = '0;
        body_left  = '0;
        fmt_pos    = '0;
        fmt_code   = '0;
        chan_cnt   = DEFAULT_CHAN;
        rate_val   = DEFAULT_RATE;
        bits_val   = DEFAULT_BITS;
        lo_valid   = 1'b0;
        lo_byte    = '0;
        err_code   = ST_OK;
    endfunction

    function automatic void begin_chunk_header();
        ph      = PH_CHDR;
        hdr_pos = '0;
        cur_tag = '0;
        cur_len = '0;
    endfunction

    // channel count and rate are whatever has been captured so far
    function automatic void push_result(input logic kind, input logic [15:0] smp,
                                        input logic [1:0] st, input logic fin);
        t_out r;
        r.kind          = kind;
        r.sample        = smp;
        r.status        = st;
        r.channel_count = chan_cnt;
        r.rate_hz       = rate_val;
        r.last          = fin;
        expected_beats.push_back(r);
    endfunction

    function automatic void parse_wav_byte(input t_in beat);
        logic [7:0]  b;
        logic [5:0]  pos;
        logic [31:0] shifted;
        logic        check;
        logic [1:0]  st;
        b     = beat.file_byte;
        pos   = seen_bytes;
        check = 1'b0;
        shifted = '0;
        if (seen_bytes < MIN_FILE_BYTES)
            seen_bytes = seen_bytes + 6'd1;

        case (ph)
            PH_RIFF: begin
                // "RIFF" at 0..3, "WAVE" at 8..11, RIFF length ignored
                if (pos < 6'd4) begin
                    shifted = TAG_RIFF >> (8 * pos);
                    check   = 1'b1;
                end else if (pos >= 6'd8 && pos < 6'd12) begin
                    shifted = TAG_WAVE >> (8 * (pos - 6'd8));
                    check   = 1'b1;
                end
                if (check && b != shifted[7:0]) begin
                    err_code = ST_NOTWAVE;
                    ph       = PH_ERROR;
                end else if (pos >= 6'd11) begin
                    begin_chunk_header();
                end
            end
            PH_CHDR: begin
                if (hdr_pos < 3'd4)
                    cur_tag[{hdr_pos[1:0], 3'b000} +: 8] = b;
                else
                    cur_len[{hdr_pos[1:0], 3'b000} +: 8] = b;
                hdr_pos = hdr_pos + 3'd1;
                if (hdr_pos == 3'd0) begin
                    if (cur_tag == TAG_DATA) begin
                        if (fmt_code != FMT_PCM || bits_val != DEFAULT_BITS) begin
                            err_code = ST_BADFMT;
                            ph       = PH_ERROR;
                        end else begin
                            body_left = {1'b0, cur_len};
                            lo_valid  = 1'b0;
                            ph        = (cur_len != 0) ? PH_DATA : PH_DONE;
                        end
                    end else begin
                        body_left = {1'b0, cur_len} + cur_len[0];
                        fmt_pos   = '0;
                        if (body_left == 0)
                            begin_chunk_header();
                        else
                            ph = (cur_tag == TAG_FMT) ? PH_FMT : PH_SKIP;
                    end
                end
            end
            PH_FMT, PH_SKIP: begin
                // only bytes inside the fmt body count, never its pad byte
                if (ph == PH_FMT && fmt_pos < FMT_BODY_MAX && {27'b0, fmt_pos} < cur_len) begin
                    if (fmt_pos < 5'd2)
                        fmt_code[{fmt_pos[0], 3'b000} +: 8] = b;
                    else if (fmt_pos < 5'd4)
                        chan_cnt[{fmt_pos[0], 3'b000} +: 8] = b;
                    else if (fmt_pos < 5'd8)
                        rate_val[{fmt_pos[1:0], 3'b000} +: 8] = b;
                    else if (fmt_pos >= 5'd14)
                        bits_val[{fmt_pos[0], 3'b000} +: 8] = b;
                end
                if (fmt_pos < FMT_BODY_MAX)
                    fmt_pos = fmt_pos + 5'd1;
                body_left = body_left - 33'd1;
                if (body_left == 0)
                    begin_chunk_header();
            end
            PH_DATA: begin
                if (lo_valid) begin
                    push_result(KIND_SAMPLE, {b, lo_byte}, ST_OK, 1'b0);
                    lo_valid = 1'b0;
                end else begin
                    lo_valid = 1'b1;
                    lo_byte  = b;
                end
                body_left = body_left - 33'd1;
                if (body_left == 0)
                    ph = PH_DONE;
            end
            default: ;
        endcase

        if (beat.end_of_file) begin
            // short file beats every other status
            if (seen_bytes < MIN_FILE_BYTES)
                st = ST_NOTWAVE;
            else if (err_code != ST_OK)
                st = err_code;
            else if (ph == PH_DATA || ph == PH_DONE)
                st = ST_OK;
            else
                st = ST_NODATA;
            push_result(KIND_STATUS, 16'h0000, st, 1'b1);
            clear_parser_model();
        end
    endfunction

    // -------------------------------------------------------------------------
    // Result checker: every accepted output beat against the oldest prediction
    // -------------------------------------------------------------------------
    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_beats.size() == 0) begin
                $error("output beat with nothing predicted: %p", o_out);
                fail_count++;
            end else begin
                want = expected_beats.pop_front();
                check_field("kind",          {31'b0, want.kind},          {31'b0, o_out.kind});
                check_field("sample",        {16'b0, want.sample},        {16'b0, o_out.sample});
                check_field("status",        {30'b0, want.status},        {30'b0, o_out.status});
                check_field("channel_count", {16'b0, want.channel_count},
                            {16'b0, o_out.channel_count});
                check_field("rate_hz",       want.rate_hz,                o_out.rate_hz);
                check_field("last",          {31'b0, want.last},          {31'b0, o_out.last});
            end
        end
    end

    // -------------------------------------------------------------------------
    // Sink: random stalls, plus a forced hold-off when a test asks for one
    // -------------------------------------------------------------------------
    function automatic int idle_len();
        if ($urandom_range(9) == 0)
            return $urandom_range(8, 30);
        return $urandom_range(1, 3);
    endfunction

    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold > 0) begin
                i_out_ready <= 1'b0;
                rx_hold--;
            end else if (rx_stall > 0) begin
                i_out_ready <= 1'b0;
                rx_stall--;
            end else if ($urandom_range(99) < rx_stall_pct) begin
                i_out_ready <= 1'b0;
                rx_stall = idle_len() - 1;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // -------------------------------------------------------------------------
    // Source side: one byte beat per call, prediction on acceptance
    // -------------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input logic eof);
        t_in beat;
        int  gap;
        beat.file_byte   = b;
        beat.end_of_file = eof;
        gap = ($urandom_range(99) < tx_gap_pct) ? idle_len() : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= beat;
        do @(posedge i_clk); while (!o_in_ready);
        bytes_sent++;
        parse_wav_byte(beat);
    endtask

    // sends the file built in wav_bytes, flagging its last byte
    task automatic send_wav();
        for (int i = 0; i < wav_bytes.size(); i++)
            send_byte(wav_bytes[i], i == wav_bytes.size() - 1);
        wav_bytes.delete();
    endtask

    // source goes quiet until every predicted beat has been seen
    task automatic wait_all_results();
        i_in_valid <= 1'b0;
        while (expected_beats.size() != 0)
            @(posedge i_clk);
    endtask

    // -------------------------------------------------------------------------
    // File builders
    // -------------------------------------------------------------------------
    function automatic void put_le(input logic [31:0] v, input int n);
        for (int i = 0; i < n; i++)
            wav_bytes.push_back(v[8 * i +: 8]);
    endfunction

    function automatic void put_random(input int n);
        repeat (n) wav_bytes.push_back(8'($urandom));
    endfunction

    function automatic void put_riff_head();
        put_le(TAG_RIFF, 4);
        put_le($urandom, 4);
        put_le(TAG_WAVE, 4);
    endfunction

    // fmt chunk of any length: standard 16-byte layout, random beyond it, pad if odd
    function automatic void put_fmt(input int len, input logic [15:0] code,
                                    input logic [15:0] ch, input logic [31:0] rate,
                                    input logic [15:0] bits);
        logic [127:0] img;
        img = {bits, 16'($urandom), 32'($urandom), rate, ch, code};
        put_le(TAG_FMT, 4);
        put_le(len, 4);
        for (int i = 0; i < len; i++)
            wav_bytes.push_back(i < 16 ? img[8 * i +: 8] : 8'($urandom));
        if (len % 2)
            put_random(1);
    endfunction

    function automatic void put_chunk(input logic [31:0] tag, input int len);
        put_le(tag, 4);
        put_le(len, 4);
        put_random(len + len % 2);
    endfunction

    function automatic void put_data_head(input logic [31:0] len);
        put_le(TAG_DATA, 4);
        put_le(len, 4);
    endfunction

    // file with random content, mostly well-formed; sizes kept small
    function automatic void put_random_wav();
        int          dlen;
        int          present;
        logic [15:0] code;
        logic [15:0] bits;
        put_riff_head();
        if ($urandom_range(3) == 0)
            put_chunk($urandom, $urandom_range(0, 7));
        if ($urandom_range(9) != 0) begin
            code = ($urandom_range(7) != 0) ? FMT_PCM : 16'($urandom);
            bits = ($urandom_range(7) != 0) ? DEFAULT_BITS : 16'($urandom);
            put_fmt(($urandom_range(3) != 0) ? 16 : $urandom_range(0, 20), code,
                    ($urandom_range(3) != 0) ? 16'($urandom_range(1, 8)) : 16'($urandom),
                    $urandom, bits);
        end
        if ($urandom_range(4) == 0)
            put_chunk($urandom, $urandom_range(0, 5));
        dlen = $urandom_range(0, 40);
        if ($urandom_range(7) == 0) begin
            // huge declared length, file ends first
            put_data_head($urandom);
            put_random($urandom_range(0, 30));
        end else begin
            put_data_head(dlen);
            present = ($urandom_range(3) == 0) ? $urandom_range(0, dlen) : dlen;
            put_random(present);
            if (present == dlen && $urandom_range(2) == 0)
                put_random($urandom_range(1, 6));   // ignored trailer
        end
    endfunction

    // -------------------------------------------------------------------------
    // Directed tests
    // -------------------------------------------------------------------------

    // bad RIFF or WAVE tag bytes, and the one-byte file
    task automatic test_tag_checks();
        tx_gap_pct   = 20;
        rx_stall_pct = 20;
        put_le(8'hFF, 1);
        send_wav();
        put_le(TAG_RIFF ^ 32'h0000_FF00, 4);
        put_random(8);
        send_wav();
        put_le(TAG_RIFF, 4);
        put_le(32'd36, 4);
        put_le(TAG_WAVE ^ 32'h8000_0000, 4);
        put_random(8);
        send_wav();
        wait_all_results();
    endtask

    // valid PCM16 stream under 44 bytes: samples come out, then the short status,
    // the last byte closing a sample too
    task automatic test_short_file();
        tx_gap_pct   = 0;
        rx_stall_pct = 0;
        put_riff_head();
        put_fmt(2, FMT_PCM, 16'd2, 32'd8000, DEFAULT_BITS);
        put_data_head(32'd6);
        put_le(32'h7FFF_8000, 4);
        put_le(16'h0000, 2);
        send_wav();
        wait_all_results();
    endtask

    // file ends inside a skipped body or inside a chunk header
    task automatic test_missing_data();
        tx_gap_pct   = 30;
        rx_stall_pct = 30;
        put_riff_head();
        put_fmt(16, FMT_PCM, 16'd1, 32'd44100, DEFAULT_BITS);
        put_le(32'h5453_494C, 4);
        put_le(32'd101, 4);
        put_random(1);
        send_wav();
        put_riff_head();
        put_fmt(16, FMT_PCM, 16'd1, 32'd48000, DEFAULT_BITS);
        put_chunk($urandom, 3);
        put_le(TAG_DATA, 4);
        put_random(2);
        send_wav();
        wait_all_results();
    endtask

    // no fmt, empty fmt, float, 8-bit: all refused when the data header ends;
    // every file is 44 bytes so the short-file status does not mask the result
    task automatic test_bad_format();
        tx_gap_pct   = 10;
        rx_stall_pct = 10;
        put_riff_head();
        put_data_head(32'd30);
        put_random(24);
        send_wav();
        put_riff_head();
        put_fmt(0, FMT_PCM, 16'd1, 32'd1, DEFAULT_BITS);
        put_data_head(32'd24);
        put_random(16);
        send_wav();
        put_riff_head();
        put_fmt(16, 16'd3, 16'd2, 32'd96000, 16'd32);
        put_data_head(32'd8);
        send_wav();
        put_riff_head();
        put_fmt(16, FMT_PCM, 16'd1, 32'd8000, 16'd8);
        put_data_head(32'd8);
        send_wav();
        wait_all_results();
    endtask

    // short, odd and oversize fmt bodies, several fmt chunks, field extremes
    task automatic test_fmt_layouts();
        tx_gap_pct   = 0;
        rx_stall_pct = 40;
        put_riff_head();
        put_fmt(6, FMT_PCM, 16'hFFFF, 32'hFFFF_FFFF, DEFAULT_BITS);
        put_fmt(15, FMT_PCM, 16'h0000, 32'h0000_0000, DEFAULT_BITS);
        put_data_head(32'd4);
        put_le(32'hFFFF_0000, 4);
        send_wav();
        put_riff_head();
        put_chunk($urandom, 1);
        put_fmt(20, FMT_PCM, 16'hFFFF, 32'hFFFF_FFFF, DEFAULT_BITS);
        put_data_head(32'd4);
        put_random(4);
        send_wav();
        wait_all_results();
    endtask

    // empty data, odd data length with trailer, truncated huge data
    task automatic test_data_edges();
        tx_gap_pct   = 40;
        rx_stall_pct = 0;
        put_riff_head();
        put_fmt(16, FMT_PCM, 16'd2, 32'd22050, DEFAULT_BITS);
        put_data_head(32'd0);
        put_random(1);
        send_wav();
        put_riff_head();
        put_fmt(16, FMT_PCM, 16'd1, 32'd16000, DEFAULT_BITS);
        put_data_head(32'd5);
        put_random(9);
        send_wav();
        put_riff_head();
        put_fmt(16, FMT_PCM, 16'd1, 32'd11025, DEFAULT_BITS);
        put_data_head(32'hFFFF_FFFF);
        put_random(3);
        send_wav();
        wait_all_results();
    endtask

    // sink holds off for a long stretch while the source keeps streaming samples,
    // so the output queue fills and the input side has to stall
    task automatic test_output_backpressure();
        tx_gap_pct   = 0;
        rx_stall_pct = 0;
        rx_hold      = 80;
        put_riff_head();
        put_fmt(16, FMT_PCM, 16'd2, 32'd44100, DEFAULT_BITS);
        put_data_head(32'd32);
        put_random(32);
        send_wav();
        wait_all_results();
    endtask

    // -------------------------------------------------------------------------
    // Random files: mostly well-formed, some corrupted, truncated or pure noise
    // -------------------------------------------------------------------------
    task automatic test_random_files();
        int pick;
        int cut;
        // tops the run up to its overall byte budget
        while (bytes_sent < 750) begin
            pick = $urandom_range(2);
            tx_gap_pct   = (pick == 0) ? 0 : (pick == 1) ? 10 : 40;
            pick = $urandom_range(2);
            rx_stall_pct = (pick == 0) ? 0 : (pick == 1) ? 10 : 40;
            pick = $urandom_range(99);
            if (pick < 90)
                put_random_wav();
            else
                put_random($urandom_range(1, 60));
            if (pick >= 65 && pick < 78) begin
                wav_bytes[$urandom_range(0, wav_bytes.size() - 1)] = 8'($urandom);
            end else if (pick >= 78 && pick < 90) begin
                cut = $urandom_range(1, wav_bytes.size());
                while (wav_bytes.size() > cut)
                    void'(wav_bytes.pop_back());
            end
            send_wav();
            if ($urandom_range(7) == 0)
                wait_all_results();
        end
        wait_all_results();
    endtask

    // -------------------------------------------------------------------------
    // Sequence
    // -------------------------------------------------------------------------
    initial begin
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in       = '0;
        clear_parser_model();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_tag_checks();
        test_short_file();
        test_missing_data();
        test_bad_format();
        test_fmt_layouts();
        test_data_edges();
        test_output_backpressure();
        test_random_files();

        // drain with the sink open, then give any stray beat time to show up
        rx_stall_pct = 0;
        wait_all_results();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// File: filelist.f
design/rwp_pkg.sv
design/rwp_front.sv
design/rwp_fifo.sv
design/rwp_back.sv
design/riff_wave_pcm16_parser.sv
design/rwp_chk.sv
tb/tb_riff_wave_pcm16_parser.sv
